### sv/dual_window_matrix_accumulator_defines.svh
// assertion macros for the dual window matrix accumulator
`ifndef DUAL_WINDOW_MATRIX_ACCUMULATOR_DEFINES_SVH
`define DUAL_WINDOW_MATRIX_ACCUMULATOR_DEFINES_SVH

// antecedent holds in a cycle, consequent must hold in the same cycle
`define DWMA_ASSERT_NOW(label, clock, rstn, ante, cons, msg) \
	label: assert property (@(posedge clock) disable iff (!(rstn)) \
		(ante) |-> (cons)) else $error(msg);

// antecedent holds in a cycle, consequent must hold in the next cycle
`define DWMA_ASSERT_NEXT(label, clock, rstn, ante, cons, msg) \
	label: assert property (@(posedge clock) disable iff (!(rstn)) \
		(ante) |=> (cons)) else $error(msg);

`endif

### sv/dwma_pkg.sv
// shared constants, types and helpers of the dual window matrix accumulator
package dwma_pkg;

	localparam int MatrixElements = 4096;
	localparam int AddrW = $clog2(MatrixElements);
	localparam int IdxW = 12;
	localparam int NumSamples = 8;
	localparam int SampleW = 32;
	localparam int PairW = SampleW + 1;
	localparam int SumW = SampleW + $clog2(NumSamples);
	localparam int AccW = 48;

	typedef logic [AddrW-1:0] addr_t;
	typedef logic [IdxW-1:0] idx_t;
	typedef logic [SumW-1:0] sum_t;
	typedef logic [AccW-1:0] acc_t;
	typedef logic [AccW:0] acc_wide_t;
	typedef logic [NumSamples-1:0][SampleW-1:0] sample_vec_t;
	typedef logic [NumSamples/2-1:0][PairW-1:0] pair_vec_t;

	// stage load enables of the adder tree
	typedef struct packed {
		logic en_s1;
		logic en_s2;
	} pipe_en_t;

	// outcome of the accumulator update for one word
	typedef struct packed {
		logic wr;
		acc_t normal;
		acc_t burst;
	} upd_t;

	function automatic logic elem_in_range(idx_t idx);
		return 32'(idx) < 32'(MatrixElements);
	endfunction

	function automatic addr_t to_addr(idx_t idx);
		return AddrW'(idx);
	endfunction

	// clamp a 49-bit two's complement sum into 48 bits
	function automatic acc_t sat_acc(acc_wide_t wide);
		acc_t res;
		res = wide[AccW-1:0];
		if (wide[AccW] != wide[AccW-1]) begin
			res = {wide[AccW], {(AccW-1){~wide[AccW]}}};
		end
		return res;
	endfunction

endpackage

### sv/dual_window_matrix_accumulator.sv
// top level of the dual window matrix accumulator
// usage:
// - input channel item_valid/item_stall carries one word per element: the element
//   index, eight signed 32-bit samples and the two restart flags
// - result channel result_valid/result_stall returns one word per input word, in
//   order, with the index, both 48-bit saturated totals and the bad_mode flag
// - one word may enter every cycle unless item_stall is high; a result word is
//   presented from the last of three register stages behind its input word (pair
//   sums, sum plus memory read, accumulate plus memory write and result register)
// - a stalled result holds; upstream stages keep filling bubbles, so input is
//   stalled only when all three stages are occupied and the result is stalled
// - a read of an element written by the word just ahead is forwarded, so words
//   with the same index may follow back to back
// - reset empties the pipeline; accumulator memories are not cleared and must be
//   loaded with a restart before an element is accumulated
`include "dual_window_matrix_accumulator_defines.svh"

module dual_window_matrix_accumulator (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          item_valid,
	output logic                          item_stall,
	input  logic [dwma_pkg::IdxW-1:0]     element_index,
	input  logic signed [dwma_pkg::SampleW-1:0] sample_0,
	input  logic signed [dwma_pkg::SampleW-1:0] sample_1,
	input  logic signed [dwma_pkg::SampleW-1:0] sample_2,
	input  logic signed [dwma_pkg::SampleW-1:0] sample_3,
	input  logic signed [dwma_pkg::SampleW-1:0] sample_4,
	input  logic signed [dwma_pkg::SampleW-1:0] sample_5,
	input  logic signed [dwma_pkg::SampleW-1:0] sample_6,
	input  logic signed [dwma_pkg::SampleW-1:0] sample_7,
	input  logic                          restart_normal,
	input  logic                          restart_burst,
	output logic                          result_valid,
	input  logic                          result_stall,
	output logic [dwma_pkg::IdxW-1:0]     result_index,
	output logic signed [dwma_pkg::AccW-1:0] normal_total,
	output logic signed [dwma_pkg::AccW-1:0] burst_total,
	output logic                          bad_mode
);

	import dwma_pkg::*;

	logic        valid_s1, valid_s2, valid_s3;
	logic        en_s1, en_s2, en_s3;
	pipe_en_t    pen;
	sample_vec_t samples;
	sum_t        sum;

	idx_t        idx_s1, idx_s2, idx_s3;
	logic        rn_s1, rn_s2;
	logic        rb_s1, rb_s2;
	logic        bad_s2, bad_s3;
	logic        fwd_hit_s2;
	acc_t        fwd_normal_s2, fwd_burst_s2;
	acc_t        normal_s3, burst_s3;

	logic        ram_we, ram_re;
	addr_t       waddr, raddr;
	acc_t        rd_normal, rd_burst;
	acc_t        old_normal, old_burst;
	upd_t        upd;

	// a stage loads when it is empty or its content moves on
	assign en_s3 = !valid_s3 || !result_stall;
	assign en_s2 = !valid_s2 || en_s3;
	assign en_s1 = !valid_s1 || en_s2;
	assign item_stall = !en_s1;
	assign pen = '{en_s1: en_s1, en_s2: en_s2};

	assign samples = {sample_7, sample_6, sample_5, sample_4,
		sample_3, sample_2, sample_1, sample_0};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (en_s1) begin
				valid_s1 <= item_valid;
			end
			if (en_s2) begin
				valid_s2 <= valid_s1;
			end
			if (en_s3) begin
				valid_s3 <= valid_s2;
			end
		end
	end

	dwma_sum_tree u_sum_tree (
		.clk     (clk),
		.pen     (pen),
		.samples (samples),
		.sum     (sum)
	);

	// read when a word moves into stage two, write when it moves into stage three
	assign raddr = to_addr(idx_s1);
	assign ram_re = en_s2 && valid_s1;
	assign waddr = to_addr(idx_s2);
	assign ram_we = valid_s2 && en_s3 && upd.wr;

	dwma_ram #(.Width(AccW), .Depth(MatrixElements)) u_normal_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (waddr),
		.wdata (upd.normal),
		.re    (ram_re),
		.raddr (raddr),
		.rdata (rd_normal)
	);

	dwma_ram #(.Width(AccW), .Depth(MatrixElements)) u_burst_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (waddr),
		.wdata (upd.burst),
		.re    (ram_re),
		.raddr (raddr),
		.rdata (rd_burst)
	);

	always_ff @(posedge clk) begin
		if (en_s1) begin
			idx_s1 <= element_index;
			rn_s1 <= restart_normal;
			rb_s1 <= restart_burst;
		end
		if (en_s2) begin
			idx_s2 <= idx_s1;
			rn_s2 <= rn_s1;
			rb_s2 <= rb_s1;
			// same edge write to the address being read: ram returns old data
			fwd_hit_s2 <= ram_we && (waddr == raddr);
			fwd_normal_s2 <= upd.normal;
			fwd_burst_s2 <= upd.burst;
		end
		if (en_s3) begin
			idx_s3 <= idx_s2;
			normal_s3 <= upd.normal;
			burst_s3 <= upd.burst;
			bad_s3 <= bad_s2;
		end
	end

	assign bad_s2 = rn_s2 && !rb_s2;
	assign old_normal = fwd_hit_s2 ? fwd_normal_s2 : rd_normal;
	assign old_burst = fwd_hit_s2 ? fwd_burst_s2 : rd_burst;

	dwma_update u_update (
		.old_normal     (old_normal),
		.old_burst      (old_burst),
		.sum            (sum),
		.restart_normal (rn_s2),
		.restart_burst  (rb_s2),
		.in_range       (elem_in_range(idx_s2)),
		.upd            (upd)
	);

	assign result_valid = valid_s3;
	assign result_index = idx_s3;
	assign normal_total = normal_s3;
	assign burst_total = burst_s3;
	assign bad_mode = bad_s3;

	`DWMA_ASSERT_NOW(a_no_input_block, clk, arst_n, !result_stall, !item_stall,
		"input stalled while results flow")
	`DWMA_ASSERT_NOW(a_write_only_good, clk, arst_n, ram_we, valid_s2 && !bad_s2,
		"accumulator written by a bubble or a bad mode word")
	`DWMA_ASSERT_NEXT(a_dual_restart, clk, arst_n, en_s3 && valid_s2 && rn_s2 && rb_s2,
		normal_total == burst_total, "dual restart gave different totals")

endmodule

### sv/dwma_ram.sv
// generic single write port ram with registered read
module dwma_ram #(
	parameter int Width = 48,
	parameter int Depth = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]         rdata
);

	logic [Width-1:0] mem_q [Depth];
	logic [Width-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

### sv/dwma_sum_tree.sv
// two stage adder tree summing the eight samples of a word
module dwma_sum_tree (
	input  logic                 clk,
	input  dwma_pkg::pipe_en_t   pen,
	input  dwma_pkg::sample_vec_t samples,
	output dwma_pkg::sum_t       sum
);

	import dwma_pkg::*;

	pair_vec_t pair_s1;
	sum_t      sum_s2;
	sum_t      sum_c;

	// first level: pairwise sign extended adds
	always_ff @(posedge clk) begin
		if (pen.en_s1) begin
			for (int k = 0; k < NumSamples/2; k++) begin
				pair_s1[k] <= {samples[2*k][SampleW-1], samples[2*k]} +
					{samples[2*k+1][SampleW-1], samples[2*k+1]};
			end
		end
	end

	always_comb begin
		sum_c = '0;
		for (int k = 0; k < NumSamples/2; k++) begin
			sum_c = sum_c + {{(SumW-PairW){pair_s1[k][PairW-1]}}, pair_s1[k]};
		end
	end

	always_ff @(posedge clk) begin
		if (pen.en_s2) begin
			sum_s2 <= sum_c;
		end
	end

	assign sum = sum_s2;

endmodule

### sv/dwma_update.sv
// restart selection and saturating accumulate for both windows
module dwma_update (
	input  dwma_pkg::acc_t old_normal,
	input  dwma_pkg::acc_t old_burst,
	input  dwma_pkg::sum_t sum,
	input  logic           restart_normal,
	input  logic           restart_burst,
	input  logic           in_range,
	output dwma_pkg::upd_t upd
);

	import dwma_pkg::*;

	acc_wide_t wide_n;
	acc_wide_t wide_b;
	acc_t      sum_ext;
	logic      bad;

	assign bad = restart_normal && !restart_burst;
	assign sum_ext = {{(AccW-SumW){sum[SumW-1]}}, sum};
	assign wide_n = {old_normal[AccW-1], old_normal} + {sum_ext[AccW-1], sum_ext};
	assign wide_b = {old_burst[AccW-1], old_burst} + {sum_ext[AccW-1], sum_ext};

	always_comb begin
		upd.wr = in_range && !bad;
		if (!in_range) begin
			upd.normal = '0;
			upd.burst = '0;
		end else if (bad) begin
			upd.normal = old_normal;
			upd.burst = old_burst;
		end else begin
			upd.normal = restart_normal ? sum_ext : sat_acc(wide_n);
			upd.burst = restart_burst ? sum_ext : sat_acc(wide_b);
		end
	end

endmodule
